// ===== rtl/nppl_pkg.sv =====
// nppl_pkg: shared constants, codes and control/status structs of the
// nearest path point / lateral error block; no dependencies
`default_nettype none

package nppl_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 32;
    localparam int ACT_W      = 2;
    localparam int IDX_OUT_W  = 10;

    // arithmetic widths
    localparam int MAG_W      = COORD_W;          // magnitude of a coordinate difference
    localparam int MUL_W      = MAG_W + 1;        // multiplier operand
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SQ_W       = 2 * MAG_W;        // one square or cross product
    localparam int SUM_W      = SQ_W + 1;         // sum of two of them
    localparam int NH_W       = SUM_W - MUL_W;    // high part of the numerator
    localparam int TSQ_W      = 2 * SUM_W + 2;    // four times numerator squared
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = DIV_STEPS / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int Q_W        = SQRT_STEPS;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        MUL_SCAN,
        MUL_DEN,
        MUL_NUM,
        MUL_NSQ_A,
        MUL_NSQ_B
    } mul_sel_t;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_SEG_B,
        RD_SEG_N
    } rd_sel_t;

    typedef struct packed {
        logic     do_clear;
        logic     do_append;
        logic     query_start;
        logic     rd_en;
        rd_sel_t  rd_sel;
        mul_sel_t mul_sel;
        logic     cap_b;
        logic     cap_n;
        logic     den_cap;
        logic     num_cap;
        logic     acc_init;
        logic     acc_add;
        logic     div_start;
        logic     load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic few_points;
        logic scan_last;
        logic pipe_busy;
        logic dx_zero;
        logic dy_zero;
        logic div_done;
        logic out_stalled;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/nppl_in_if.sv =====
// nppl_in_if: valid/ready channel carrying one input transaction
// depends on nppl_pkg
`default_nettype none

interface nppl_in_if
    import nppl_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [ACT_W-1:0]           action;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;

    modport source (output valid, action, coord_x, coord_y, input ready);
    modport sink   (input valid, action, coord_x, coord_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/nppl_out_if.sv =====
// nppl_out_if: valid/ready channel carrying one result transaction
// depends on nppl_pkg
`default_nettype none

interface nppl_out_if
    import nppl_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [IDX_OUT_W-1:0]       nearest_index;
    logic signed [COORD_W-1:0]  nearest_x;
    logic signed [COORD_W-1:0]  nearest_y;
    logic signed [COORD_W-1:0]  track_error;

    modport source (output valid, status, nearest_index, nearest_x, nearest_y,
                    track_error, input ready);
    modport sink   (input valid, status, nearest_index, nearest_x, nearest_y,
                    track_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/nppl_rdsq.sv =====
// nppl_rdsq: iterative rounded N / sqrt(D) unit, restoring division of 4*N^2
// by D one bit a cycle, then a bit-pair integer square root; uses nppl_pkg
`default_nettype none

module nppl_rdsq
    import nppl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [TSQ_W-1:0]  tsq,
    input  wire logic [SUM_W-1:0]  den,
    output logic                   done,
    output logic [Q_W-1:0]         q
);

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_DIV,
        RS_SQRT
    } rs_state_t;

    localparam int HI_W = TSQ_W - DIV_STEPS;

    rs_state_t              state_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   done_reg;
    logic [SUM_W-1:0]       rem_reg;
    logic [DIV_STEPS-1:0]   lo_reg;
    logic [DIV_STEPS-1:0]   quo_reg;
    logic [MUL_W:0]         sq_rem_reg;
    logic [Q_W-1:0]         root_reg;
    logic [Q_W-1:0]         q_reg;

    logic                   ovf;
    logic [SUM_W:0]         r2;
    logic                   div_ge;
    logic [SUM_W:0]         r2_sub;
    logic [MUL_W+2:0]       rem_t;
    logic [MUL_W+2:0]       trial;
    logic                   sq_ge;
    logic [MUL_W+2:0]       rem_sub;
    logic [Q_W-1:0]         root_fin;
    logic [Q_W:0]           root_inc;

    assign ovf      = tsq[TSQ_W-1 -: HI_W] >= HI_W'(den);
    assign r2       = {rem_reg, lo_reg[DIV_STEPS-1]};
    assign div_ge   = r2 >= {1'b0, den};
    assign r2_sub   = r2 - {1'b0, den};
    assign rem_t    = {sq_rem_reg, quo_reg[DIV_STEPS-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign sq_ge    = rem_t >= trial;
    assign rem_sub  = rem_t - trial;
    assign root_fin = {root_reg[Q_W-2:0], sq_ge};
    assign root_inc = {1'b0, root_fin} + (Q_W+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                RS_IDLE:
                begin
                    if (start)
                    begin
                        step_reg <= '0;
                        if (ovf)
                        begin
                            q_reg    <= Q_W'(1) << (Q_W - 1);
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            rem_reg   <= tsq[DIV_STEPS +: SUM_W];
                            lo_reg    <= tsq[DIV_STEPS-1:0];
                            state_reg <= RS_DIV;
                        end
                    end
                end
                RS_DIV:
                begin
                    rem_reg  <= div_ge ? r2_sub[SUM_W-1:0] : r2[SUM_W-1:0];
                    lo_reg   <= {lo_reg[DIV_STEPS-2:0], 1'b0};
                    quo_reg  <= {quo_reg[DIV_STEPS-2:0], div_ge};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        sq_rem_reg <= '0;
                        root_reg   <= '0;
                        step_reg   <= '0;
                        state_reg  <= RS_SQRT;
                    end
                end
                RS_SQRT:
                begin
                    sq_rem_reg <= sq_ge ? rem_sub[MUL_W:0] : rem_t[MUL_W:0];
                    root_reg   <= root_fin;
                    quo_reg    <= {quo_reg[DIV_STEPS-3:0], 2'b00};
                    step_reg   <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(SQRT_STEPS - 1))
                    begin
                        // largest odd t <= root gives q = (root + 1) / 2
                        q_reg     <= root_inc[Q_W:1];
                        done_reg  <= 1'b1;
                        state_reg <= RS_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= RS_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

`default_nettype wire

// ===== rtl/nppl_dp.sv =====
// nppl_dp: datapath with point memories, scan pipeline, segment arithmetic
// and result register; uses nppl_pkg, nppl_out_if and nppl_rdsq
`default_nettype none

module nppl_dp
    import nppl_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ctrl_cmd_t                  cmd,
    input  wire logic signed [COORD_W-1:0]  coord_x,
    input  wire logic signed [COORD_W-1:0]  coord_y,
    output dp_status_t                      status,
    nppl_out_if.source                      result
);

    // point memories
    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];

    logic [CNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]  scan_addr_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [COORD_W-1:0] rdx_reg, rdy_reg;
    logic [COORD_W-1:0] pos_x_reg, pos_y_reg;
    logic               few_reg;

    // scan pipeline
    logic               v1_reg, v2_reg, v3_reg;
    logic [ADDR_W-1:0]  idx1_reg, idx2_reg, idx3_reg;
    logic [COORD_W-1:0] px2_reg, py2_reg, px3_reg, py3_reg;
    logic [MAG_W-1:0]   ax_reg, ay_reg;
    logic [COORD_W:0]   dpx, dpy;

    logic               best_valid_reg;
    logic [SUM_W-1:0]   best_d_reg;
    logic [ADDR_W-1:0]  best_idx_reg;
    logic [COORD_W-1:0] best_x_reg, best_y_reg;
    logic [SUM_W-1:0]   sq_sum;

    // segment arithmetic
    logic [ADDR_W-1:0]  ib, inx;
    logic [COORD_W-1:0] xb_reg, yb_reg;
    logic [COORD_W:0]   dx_reg, dy_reg, ex_reg, ey_reg;
    logic [MAG_W-1:0]   adx, ady, aex, aey;
    logic [MUL_W-1:0]   ma0, mb0, ma1, mb1;
    logic [PROD_W-1:0]  prod0_reg, prod1_reg;
    logic [SUM_W-1:0]   den_reg;
    logic [SUM_W-1:0]   num_reg;
    logic               num_neg_reg;
    logic [SUM_W-1:0]   num_mag;
    logic               num_neg;
    logic               na, nb;
    logic [TSQ_W-1:0]   acc_reg;
    logic               div_done;
    logic [Q_W-1:0]     q;
    logic [COORD_W-1:0] lat_sel;
    logic signed [COORD_W+1:0] q_s;

    // result register
    logic               out_valid_reg;
    logic               out_status_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg, out_lat_reg;

    function automatic logic [MAG_W-1:0] mag33(input logic [COORD_W:0] v);
        logic [COORD_W:0] n;
        n = -v;
        return v[COORD_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] sat34(input logic signed [COORD_W+1:0] v);
        logic signed [COORD_W+1:0] hi, lo;
        hi = (COORD_W+2)'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
        lo = -(COORD_W+2)'(64'sd1 <<< (COORD_W - 1));
        if (v > hi)
        begin
            return hi[COORD_W-1:0];
        end
        if (v < lo)
        begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    // ---------------- store and read port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.do_clear)
        begin
            count_reg <= '0;
        end
        else if (cmd.do_append && count_reg < CNT_W'(MAX_POINTS))
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_append && count_reg < CNT_W'(MAX_POINTS))
        begin
            mem_x[count_reg[ADDR_W-1:0]] <= coord_x;
            mem_y[count_reg[ADDR_W-1:0]] <= coord_y;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_SCAN:  rd_addr = scan_addr_reg;
            RD_SEG_B: rd_addr = ib;
            RD_SEG_N: rd_addr = inx;
            default:  rd_addr = scan_addr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdx_reg <= mem_x[rd_addr];
            rdy_reg <= mem_y[rd_addr];
        end
        if (cmd.query_start)
        begin
            pos_x_reg <= coord_x;
            pos_y_reg <= coord_y;
            few_reg   <= count_reg < CNT_W'(2);
        end
    end

    // ---------------- scan pipeline ----------------
    assign dpx    = {rdx_reg[COORD_W-1], rdx_reg} - {pos_x_reg[COORD_W-1], pos_x_reg};
    assign dpy    = {rdy_reg[COORD_W-1], rdy_reg} - {pos_y_reg[COORD_W-1], pos_y_reg};
    assign sq_sum = {1'b0, prod0_reg[SQ_W-1:0]} + {1'b0, prod1_reg[SQ_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg  <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.query_start)
            begin
                scan_addr_reg  <= '0;
                best_valid_reg <= 1'b0;
            end
            else if (cmd.rd_en && cmd.rd_sel == RD_SCAN)
            begin
                scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
            end
            v1_reg <= cmd.rd_en && cmd.rd_sel == RD_SCAN;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg && (!best_valid_reg || sq_sum < best_d_reg))
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= scan_addr_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        px2_reg  <= rdx_reg;
        py2_reg  <= rdy_reg;
        px3_reg  <= px2_reg;
        py3_reg  <= py2_reg;
        ax_reg   <= mag33(dpx);
        ay_reg   <= mag33(dpy);
        // strict compare keeps the first of equal distances
        if (v3_reg && (!best_valid_reg || sq_sum < best_d_reg))
        begin
            best_d_reg   <= sq_sum;
            best_idx_reg <= idx3_reg;
            best_x_reg   <= px3_reg;
            best_y_reg   <= py3_reg;
        end
    end

    // ---------------- segment arithmetic ----------------
    always_comb
    begin
        if ((CNT_W'(best_idx_reg) + CNT_W'(1)) < count_reg)
        begin
            ib  = best_idx_reg;
            inx = best_idx_reg + ADDR_W'(1);
        end
        else
        begin
            ib  = best_idx_reg - ADDR_W'(1);
            inx = best_idx_reg;
        end
    end

    assign adx = mag33(dx_reg);
    assign ady = mag33(dy_reg);
    assign aex = mag33(ex_reg);
    assign aey = mag33(ey_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SCAN:
            begin
                ma0 = {1'b0, ax_reg};  mb0 = {1'b0, ax_reg};
                ma1 = {1'b0, ay_reg};  mb1 = {1'b0, ay_reg};
            end
            MUL_DEN:
            begin
                ma0 = {1'b0, adx};     mb0 = {1'b0, adx};
                ma1 = {1'b0, ady};     mb1 = {1'b0, ady};
            end
            MUL_NUM:
            begin
                ma0 = {1'b0, ady};     mb0 = {1'b0, aex};
                ma1 = {1'b0, adx};     mb1 = {1'b0, aey};
            end
            MUL_NSQ_A:
            begin
                ma0 = num_reg[MUL_W-1:0];        mb0 = num_reg[MUL_W-1:0];
                ma1 = MUL_W'(num_reg[SUM_W-1 -: NH_W]);
                mb1 = num_reg[MUL_W-1:0];
            end
            MUL_NSQ_B:
            begin
                ma0 = MUL_W'(num_reg[SUM_W-1 -: NH_W]);
                mb0 = MUL_W'(num_reg[SUM_W-1 -: NH_W]);
                ma1 = '0;              mb1 = '0;
            end
            default:
            begin
                ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0;
            end
        endcase
    end

    // signs of the two cross products and their signed sum
    assign na = dy_reg[COORD_W] != ex_reg[COORD_W];
    assign nb = dx_reg[COORD_W] != ey_reg[COORD_W];

    always_comb
    begin
        if (na == nb)
        begin
            num_mag = {1'b0, prod0_reg[SQ_W-1:0]} + {1'b0, prod1_reg[SQ_W-1:0]};
            num_neg = na;
        end
        else if (prod0_reg[SQ_W-1:0] >= prod1_reg[SQ_W-1:0])
        begin
            num_mag = {1'b0, prod0_reg[SQ_W-1:0] - prod1_reg[SQ_W-1:0]};
            num_neg = na;
        end
        else
        begin
            num_mag = {1'b0, prod1_reg[SQ_W-1:0] - prod0_reg[SQ_W-1:0]};
            num_neg = nb;
        end
    end

    always_ff @(posedge clk)
    begin
        prod0_reg <= ma0 * mb0;
        prod1_reg <= ma1 * mb1;
        if (cmd.cap_b)
        begin
            xb_reg <= rdx_reg;
            yb_reg <= rdy_reg;
        end
        if (cmd.cap_n)
        begin
            dx_reg <= {rdx_reg[COORD_W-1], rdx_reg} - {xb_reg[COORD_W-1], xb_reg};
            dy_reg <= {rdy_reg[COORD_W-1], rdy_reg} - {yb_reg[COORD_W-1], yb_reg};
            ex_reg <= {pos_x_reg[COORD_W-1], pos_x_reg} - {rdx_reg[COORD_W-1], rdx_reg};
            ey_reg <= {rdy_reg[COORD_W-1], rdy_reg} - {pos_y_reg[COORD_W-1], pos_y_reg};
        end
        if (cmd.den_cap)
        begin
            den_reg <= sq_sum;
        end
        if (cmd.num_cap)
        begin
            num_reg     <= num_mag;
            num_neg_reg <= num_neg;
        end
        // 4*N^2 from three partial products, N split at the multiplier width:
        // 4*lo^2 + 8*lo*hi*2^MUL_W + 4*hi^2*2^(2*MUL_W)
        if (cmd.acc_init)
        begin
            acc_reg <= (TSQ_W'(prod0_reg) << 2) + (TSQ_W'(prod1_reg) << (MUL_W + 3));
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + (TSQ_W'(prod0_reg) << (2 * MUL_W + 2));
        end
    end

    nppl_rdsq u_rdsq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .tsq   (acc_reg),
        .den   (den_reg),
        .done  (div_done),
        .q     (q)
    );

    assign q_s = {2'b00, q};

    always_comb
    begin
        if (dx_reg == '0)
        begin
            lat_sel = sat34(-{ex_reg[COORD_W], ex_reg});
        end
        else if (dy_reg == '0)
        begin
            lat_sel = sat34(-{ey_reg[COORD_W], ey_reg});
        end
        else if (num_neg_reg != dx_reg[COORD_W])
        begin
            lat_sel = sat34(q_s);
        end
        else
        begin
            lat_sel = sat34(-q_s);
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= few_reg;
            out_idx_reg    <= few_reg ? '0 : IDX_OUT_W'(best_idx_reg);
            out_x_reg      <= few_reg ? '0 : best_x_reg;
            out_y_reg      <= few_reg ? '0 : best_y_reg;
            out_lat_reg    <= few_reg ? '0 : lat_sel;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.nearest_index = out_idx_reg;
    assign result.nearest_x     = out_x_reg;
    assign result.nearest_y     = out_y_reg;
    assign result.track_error   = out_lat_reg;

    assign status.few_points  = count_reg < CNT_W'(2);
    assign status.scan_last   = {1'b0, scan_addr_reg} == (count_reg - CNT_W'(1));
    assign status.pipe_busy   = v1_reg || v2_reg || v3_reg;
    assign status.dx_zero     = dx_reg == '0;
    assign status.dy_zero     = dy_reg == '0;
    assign status.div_done    = div_done;
    assign status.out_stalled = out_valid_reg && !result.ready;

endmodule

`default_nettype wire

// ===== rtl/nppl_ctrl.sv =====
// nppl_ctrl: controller state machine sequencing scan, segment arithmetic
// and division; uses nppl_pkg
`default_nettype none

module nppl_ctrl
    import nppl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic [ACT_W-1:0]  action,
    input  wire dp_status_t        status,
    output logic                   item_ready,
    output ctrl_cmd_t              cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SEG_B,
        S_SEG_N,
        S_DIFF,
        S_CLASS,
        S_MUL_D,
        S_MUL_N,
        S_SUM_N,
        S_NSQ_A,
        S_NSQ_B,
        S_NSQ_C,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_ready = state_reg == S_IDLE;
    assign accept     = item_ready && item_valid;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_SCAN;
        cmd.mul_sel = MUL_SCAN;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_CLEAR:  cmd.do_clear = 1'b1;
                        ACT_APPEND: cmd.do_append = 1'b1;
                        ACT_QUERY:
                        begin
                            cmd.query_start = 1'b1;
                            state_next = status.few_points ? S_OUT : S_SCAN;
                        end
                        default:    cmd.do_clear = 1'b0;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = S_SEG_B;
                end
            end
            S_SEG_B:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SEG_B;
                state_next = S_SEG_N;
            end
            S_SEG_N:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SEG_N;
                cmd.cap_b  = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.cap_n  = 1'b1;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                state_next = (status.dx_zero || status.dy_zero) ? S_OUT : S_MUL_D;
            end
            S_MUL_D:
            begin
                cmd.mul_sel = MUL_DEN;
                state_next  = S_MUL_N;
            end
            S_MUL_N:
            begin
                cmd.mul_sel = MUL_NUM;
                cmd.den_cap = 1'b1;
                state_next  = S_SUM_N;
            end
            S_SUM_N:
            begin
                cmd.num_cap = 1'b1;
                state_next  = S_NSQ_A;
            end
            S_NSQ_A:
            begin
                cmd.mul_sel = MUL_NSQ_A;
                state_next  = S_NSQ_B;
            end
            S_NSQ_B:
            begin
                cmd.mul_sel  = MUL_NSQ_B;
                cmd.acc_init = 1'b1;
                state_next   = S_NSQ_C;
            end
            S_NSQ_C:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!status.out_stalled)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nearest_path_point_lateral_error_top.sv =====
// nearest_path_point_lateral_error_top: top level joining controller and datapath
// depends on nppl_pkg, nppl_in_if, nppl_out_if, nppl_ctrl, nppl_dp
`default_nettype none

// Keeps a path of up to MAX_POINTS (1024) points in Q21.10 and answers queries
// for the nearest stored point and the lateral error to the segment through it.
// Clear and append transactions leave the controller idle and may follow back
// to back; an append to a full path is dropped and action code three does
// nothing. A query with fewer than two points goes straight to the output state
// and its result carries status 1. Otherwise a query holds the input while the
// scan reads one point per cycle through the single read port of the point
// memories, the scan pipeline drains, segment arithmetic runs on the two shared
// 33x33 multipliers, and the iterative unit does a 64-step division and a 32-step
// square root. A vertical or horizontal segment skips the multiply, division and
// root. One query is in work at a time; the result waits in an output register
// so the next transaction can be accepted while it is still pending, and a
// stalled result holds back only the next query's result. The point memories
// need no clearing pass.

module nearest_path_point_lateral_error_top
    import nppl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    nppl_in_if.sink     item,
    nppl_out_if.source  result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       item_ready;

    // controller: decodes transactions and steps the query sequence
    nppl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .action     (item.action),
        .status     (status),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    assign item.ready = item_ready;

    // datapath: memories, scan pipeline, segment math and result register
    nppl_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .coord_x (item.coord_x),
        .coord_y (item.coord_y),
        .status  (status),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== dv/tb_nearest_path_point_lateral_error_top.sv =====
// tb_nearest_path_point_lateral_error_top: self-checking testbench of the nearest path
// point / lateral error block, with directed rows and random paths
// depends on nppl_pkg, nppl_in_if, nppl_out_if and nearest_path_point_lateral_error_top
`timescale 1ns / 1ps

module tb_nearest_path_point_lateral_error_top;
    import nppl_pkg::*;

    // one expected result transaction
    typedef struct {
        logic                      status;
        logic [IDX_OUT_W-1:0]      index;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] err;
    } answer_t;

    // one row of the directed table; typed marks a row whose answer is written out
    typedef struct {
        logic [ACT_W-1:0]          action;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        bit                        typed;
        answer_t                   answer;
    } row_t;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic signed [COORD_W-1:0] CMAX = 32'sh7fffffff;
    localparam logic signed [COORD_W-1:0] CMIN = 32'sh80000000;
    localparam answer_t FEW_POINTS = '{1'b1, '0, '0, '0, '0};

    logic clk;
    logic rst_n;

    nppl_in_if  item ();
    nppl_out_if result ();

    nearest_path_point_lateral_error_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    // own copy of the path, as the block should hold it
    logic signed [COORD_W-1:0] path_xs [MAX_POINTS];
    logic signed [COORD_W-1:0] path_ys [MAX_POINTS];
    int unsigned               path_len;

    answer_t pending_answers [$];
    int      fail_count;
    int      sent_count;
    bit      calm;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // exact rounded |num| / sqrt(den), capped at 2^31
    function automatic longint round_root_ratio(logic [69:0] num, logic [69:0] den);
        logic [255:0] lhs;
        logic [255:0] rhs;
        longint       lo;
        longint       hi;
        longint       mid;
        rhs = 256'(num) * 256'(num) * 256'd4;
        lo  = 0;
        hi  = 64'd2147483648;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = 256'(2 * mid - 1);
            lhs = lhs * lhs * 256'(den);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp32(logic signed [69:0] v);
        if (v > 70'sd2147483647)
            return CMAX;
        if (v < -70'sd2147483648)
            return CMIN;
        return v[COORD_W-1:0];
    endfunction

    // negated signed distance from (x,y) to the line through points b and n
    function automatic logic signed [COORD_W-1:0] track_error_of(
        logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y, int unsigned b,
        int unsigned n);
        logic signed [69:0] dx;
        logic signed [69:0] dy;
        logic signed [69:0] ex;
        logic signed [69:0] ey;
        logic signed [69:0] num;
        logic [69:0]        den;
        longint             q;
        bit                 neg;
        dx = 70'(path_xs[n]) - 70'(path_xs[b]);
        dy = 70'(path_ys[n]) - 70'(path_ys[b]);
        ex = 70'(x) - 70'(path_xs[n]);
        ey = 70'(path_ys[n]) - 70'(y);
        if (dx == 0)
            return clamp32(-ex);
        if (dy == 0)
            return clamp32(-ey);
        num = dy * ex + dx * ey;
        den = dx * dx + dy * dy;
        neg = (num < 0) != (dx < 0);
        q = round_root_ratio(num < 0 ? -num : num, den);
        // the block reports the negated distance
        return neg ? clamp32(70'(q)) : clamp32(-70'(q));
    endfunction

    function automatic answer_t nearest_point_answer(
        logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        answer_t       a;
        logic [69:0]   sq_dist;
        logic [69:0]   best_dist;
        logic signed [69:0] ax;
        logic signed [69:0] ay;
        int unsigned   best;
        a = FEW_POINTS;
        if (path_len < 2)
            return a;
        best = 0;
        best_dist = '0;
        for (int unsigned i = 0; i < path_len; i++)
        begin
            ax = 70'(path_xs[i]) - 70'(x);
            ay = 70'(path_ys[i]) - 70'(y);
            sq_dist = ax * ax + ay * ay;
            // ties keep the lower index
            if (i == 0 || sq_dist < best_dist)
            begin
                best = i;
                best_dist = sq_dist;
            end
        end
        a.status = 1'b0;
        a.index  = best[IDX_OUT_W-1:0];
        a.px     = path_xs[best];
        a.py     = path_ys[best];
        // the last point uses the segment before it
        if (best + 1 < path_len)
            a.err = track_error_of(x, y, best, best + 1);
        else
            a.err = track_error_of(x, y, best - 1, best);
        return a;
    endfunction

    // update the path copy and, for a query, the expected answer
    function automatic void track_transaction(logic [ACT_W-1:0] action,
        logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y, bit typed,
        answer_t typed_answer);
        if (action == ACT_CLEAR)
            path_len = 0;
        else if (action == ACT_APPEND)
        begin
            // append to a full path is dropped
            if (path_len < MAX_POINTS)
            begin
                path_xs[path_len] = x;
                path_ys[path_len] = y;
                path_len++;
            end
        end
        else if (action == ACT_QUERY)
        begin
            if (typed)
                pending_answers.push_back(typed_answer);
            else
                pending_answers.push_back(nearest_point_answer(x, y));
        end
    endfunction

    // one input transaction, with an optional idle burst before it
    task automatic send_item(logic [ACT_W-1:0] action, logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y, bit typed, answer_t typed_answer);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        item.valid   <= 1'b1;
        item.action  <= action;
        item.coord_x <= x;
        item.coord_y <= y;
        do
            @(posedge clk);
        while (!item.ready);
        track_transaction(action, x, y, typed, typed_answer);
        if (action != ACT_UNUSED)
            sent_count++;
    endtask

    task automatic send_plain(logic [ACT_W-1:0] action, logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y);
        send_item(action, x, y, 1'b0, FEW_POINTS);
    endtask

    // coordinates: full range, small around zero, or near the maximum
    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 8000) - 4000;
            2:       return CMAX - $urandom_range(0, 3000);
            default: return $urandom_range(0, 60000) - 30000;
        endcase
    endfunction

    // result side: random stall bursts, none near the end
    initial
    begin
        int stall;
        result.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (calm)
                result.ready <= 1'b1;
            else if (stall > 0)
            begin
                result.ready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                result.ready <= 1'b0;
                stall = $urandom_range(0, 9);
            end
            else
                result.ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest expected answer
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result transaction");
                fail_count++;
            end
            else
            begin
                e = pending_answers.pop_front();
                if (result.status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, result.status);
                    fail_count++;
                end
                if (result.nearest_index !== e.index)
                begin
                    $error("nearest_index: expected %0d, actual %0d", e.index,
                           result.nearest_index);
                    fail_count++;
                end
                if (result.nearest_x !== e.px)
                begin
                    $error("nearest_x: expected %0d, actual %0d", e.px, result.nearest_x);
                    fail_count++;
                end
                if (result.nearest_y !== e.py)
                begin
                    $error("nearest_y: expected %0d, actual %0d", e.py, result.nearest_y);
                    fail_count++;
                end
                if (result.track_error !== e.err)
                begin
                    $error("track_error: expected %0d, actual %0d", e.err,
                           result.track_error);
                    fail_count++;
                end
            end
        end
    end

    // directed table: empty path, single point, segment kinds, extremes, unused code
    row_t rows [] = '{
        '{ACT_QUERY,  0, 0, 1'b1, FEW_POINTS},
        '{ACT_APPEND, 0, 0, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  5, 5, 1'b1, FEW_POINTS},
        '{ACT_APPEND, 1024, 0, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  512, 100, 1'b0, FEW_POINTS},
        '{ACT_APPEND, 1024, 2048, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  2000, 3000, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  1024, 1024, 1'b0, FEW_POINTS},
        '{ACT_UNUSED, 1, 1, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  -700, 40, 1'b0, FEW_POINTS},
        '{ACT_CLEAR,  0, 0, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  0, 0, 1'b1, FEW_POINTS},
        '{ACT_APPEND, CMAX, CMAX, 1'b0, FEW_POINTS},
        '{ACT_APPEND, CMIN, CMIN, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  0, 0, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  CMIN, CMAX, 1'b0, FEW_POINTS},
        '{ACT_APPEND, CMAX, CMIN, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  CMAX, CMAX, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  CMIN, CMIN, 1'b0, FEW_POINTS},
        '{ACT_CLEAR,  0, 0, 1'b0, FEW_POINTS},
        '{ACT_APPEND, 0, 0, 1'b0, FEW_POINTS},
        '{ACT_APPEND, 0, 0, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  5, 7, 1'b0, FEW_POINTS},
        '{ACT_APPEND, -1, -1, 1'b0, FEW_POINTS},
        '{ACT_QUERY,  -1, CMAX, 1'b0, FEW_POINTS}
    };

    initial
    begin
        int n;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        rst_n        = 1'b0;
        item.valid   = 1'b0;
        item.action  = ACT_CLEAR;
        item.coord_x = '0;
        item.coord_y = '0;
        path_len     = 0;
        fail_count   = 0;
        sent_count   = 0;
        calm         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_item(rows[i].action, rows[i].x, rows[i].y, rows[i].typed, rows[i].answer);

        // random short paths; mostly well-formed, with some noise
        while (sent_count < 540)
        begin
            if (sent_count > 480)
                calm = 1'b1;
            send_plain(ACT_CLEAR, random_coord(), random_coord());
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            px = random_coord();
            py = random_coord();
            for (int i = 0; i < n; i++)
            begin
                // some segments vertical or horizontal, some repeated points
                case ($urandom_range(0, 5))
                    0:       py = random_coord();
                    1:       px = random_coord();
                    2:       ;
                    default:
                    begin
                        px = random_coord();
                        py = random_coord();
                    end
                endcase
                send_plain(ACT_APPEND, px, py);
                if ($urandom_range(0, 9) == 0)
                    send_plain(ACT_UNUSED, $urandom, $urandom);
            end
            repeat ($urandom_range(1, 4))
            begin
                if (n > 0 && $urandom_range(0, 1) == 0)
                    send_plain(ACT_QUERY, path_xs[$urandom_range(0, n - 1)] +
                               $urandom_range(0, 600) - 300,
                               path_ys[$urandom_range(0, n - 1)] +
                               $urandom_range(0, 600) - 300);
                else
                    send_plain(ACT_QUERY, random_coord(), random_coord());
            end
        end
        @(negedge clk);
        item.valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nppl_pkg.sv
rtl/nppl_in_if.sv
rtl/nppl_out_if.sv
rtl/nppl_rdsq.sv
rtl/nppl_dp.sv
rtl/nppl_ctrl.sv
rtl/nearest_path_point_lateral_error_top.sv
dv/tb_nearest_path_point_lateral_error_top.sv
